### rtl/apct_pkg.sv
`timescale 1ns / 1ps

package apct_pkg;

  localparam int SLOT_COUNT_DEF = 32;
  localparam int TYPE_COUNT_DEF = 16;
  localparam int SLOT_MAX_W     = 8;
  localparam int MAX_PAIRS      = 31;
  localparam int PAIR_CNT_W     = 5;

  localparam int CMD_W    = 2;
  localparam int SLOT_F_W = 5;
  localparam int COORD_W  = 16;
  localparam int SIZE_W   = 12;
  localparam int TYPE_W   = 4;
  localparam int STATUS_W = 2;

  localparam int MASK_W    = 64;
  localparam int REG_COUNT = 4;
  localparam int CFG_IDX_W = 3;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SCAN   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MASK_0_3   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_4_7   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_8_11  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_12_15 = 3'd3;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SIZE_W-1:0]  w;
    logic [SIZE_W-1:0]  h;
  } rect_t;

  typedef struct packed {
    logic [TYPE_W-1:0] obj_type;
    rect_t             rect;
  } entry_t;

  typedef struct packed {
    logic                  we_rect;
    logic                  we_type;
    logic [SLOT_MAX_W-1:0] waddr;
    entry_t                wdata;
    logic                  re;
    logic [SLOT_MAX_W-1:0] raddr;
  } mem_req_t;

  typedef logic [REG_COUNT-1:0][MASK_W-1:0] mask_set_t;

endpackage

### rtl/apct_if.sv
`timescale 1ns / 1ps

interface apct_in_if;
  import apct_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           cmd;
  logic [SLOT_F_W-1:0]        slot;
  logic signed [COORD_W-1:0]  rect_x;
  logic signed [COORD_W-1:0]  rect_y;
  logic [SIZE_W-1:0]          rect_w;
  logic [SIZE_W-1:0]          rect_h;
  logic [TYPE_W-1:0]          obj_type;

  modport source (output valid, cmd, slot, rect_x, rect_y, rect_w, rect_h, obj_type,
                  input ready);
  modport sink (input valid, cmd, slot, rect_x, rect_y, rect_w, rect_h, obj_type,
                output ready);
endinterface

interface apct_out_if;
  import apct_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_F_W-1:0] slot_a;
  logic [SLOT_F_W-1:0] slot_b;
  logic                hit;
  logic                last;

  modport source (output valid, status, slot_a, slot_b, hit, last, input ready);
  modport sink (input valid, status, slot_a, slot_b, hit, last, output ready);
endinterface

### rtl/apct_slot_mem.sv
`timescale 1ns / 1ps

module apct_slot_mem
  import apct_pkg::*;
#(
  parameter int DEPTH = SLOT_COUNT_DEF
) (
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rd_q
);

  localparam int ADDR_W = $clog2(DEPTH);

  rect_t             rect_mem [DEPTH];
  logic [TYPE_W-1:0] type_mem [DEPTH];
  entry_t            rd_q_r;

  always_ff @(posedge clk) begin
    if (req.we_rect) begin
      rect_mem[req.waddr[ADDR_W-1:0]] <= req.wdata.rect;
    end
    if (req.we_type) begin
      type_mem[req.waddr[ADDR_W-1:0]] <= req.wdata.obj_type;
    end
    if (req.re) begin
      rd_q_r.rect     <= rect_mem[req.raddr[ADDR_W-1:0]];
      rd_q_r.obj_type <= type_mem[req.raddr[ADDR_W-1:0]];
    end
  end

  assign rd_q = rd_q_r;

endmodule

### rtl/apct_pair_eval.sv
`timescale 1ns / 1ps

module apct_pair_eval
  import apct_pkg::*;
#(
  parameter int TYPE_COUNT = TYPE_COUNT_DEF
) (
  input  entry_t    base,
  input  entry_t    cand,
  input  mask_set_t mask,
  output logic      hit
);

  localparam int SUM_W = COORD_W + 2;

  logic [TYPE_W-1:0]       r;
  logic [TYPE_W-1:0]       c;
  logic                    types_ok;
  logic                    mask_bit;
  logic [MASK_W-1:0]       row_word;
  logic signed [SUM_W-1:0] ax, ay, aw, ah, bx, by, bw, bh;
  logic                    overlap;

  assign r = base.obj_type;
  assign c = cand.obj_type;
  assign types_ok = ({1'b0, r} < 5'(TYPE_COUNT)) && ({1'b0, c} < 5'(TYPE_COUNT));
  assign row_word = mask[r[3:2]];
  assign mask_bit = types_ok && row_word[{r[1:0], c}];

  assign ax = SUM_W'($signed(base.rect.x));
  assign ay = SUM_W'($signed(base.rect.y));
  assign aw = SUM_W'($signed({1'b0, base.rect.w}));
  assign ah = SUM_W'($signed({1'b0, base.rect.h}));
  assign bx = SUM_W'($signed(cand.rect.x));
  assign by = SUM_W'($signed(cand.rect.y));
  assign bw = SUM_W'($signed({1'b0, cand.rect.w}));
  assign bh = SUM_W'($signed({1'b0, cand.rect.h}));

  assign overlap = (ax < bx + bw) && (ax + aw > bx) &&
                   (ay < by + bh) && (ay + ah > by);

  assign hit = mask_bit && overlap;

endmodule

### rtl/aabb_pair_collision_table.sv
`timescale 1ns / 1ps
// Slot table with pairwise rectangle collision scan.
// Input channel (in_*): one request per command: add, remove, update or scan.
// Output channel (out_*): add, remove and update give one result with last set.
// A scan gives one result per colliding higher slot (hit set, last on the final
// one), or a single result with hit clear when there is no pair or the slot is
// free. Configuration (cfg_*): four 64-bit pair-mask rows, written while idle.
// Sequence: remove and update go straight to the response state. Add walks the valid
// bits one per cycle from slot 0 and reports the lowest free slot, or full when
// none is free. A scan of slot s reads the slot memory once per cycle while not
// stalled, base entry first, then slots s + 1 up to SLOT_COUNT - 1, through the
// single read port of the slot memory; a free slot goes straight to the response.
// One request is worked at a time; the next is accepted in the cycle after the
// current one has handed its last result to the output register.
// Reset clears all valid bits, the pair mask and the output valid flag; rectangle
// and type storage is not cleared.
// When the receiver stalls, the output register holds its result and a scan
// pauses once it has a further pair to report.

module aabb_pair_collision_table
  import apct_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int TYPE_COUNT = TYPE_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  apct_in_if.sink              in,
  apct_out_if.source           out,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MASK_W-1:0]    cfg_wdata
);

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOT_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_FIND, S_RESP, S_BASE, S_SCAN, S_FLUSH
  } state_t;

  state_t                  state_r, state_nxt;
  logic [SLOT_COUNT-1:0]   valid_r, valid_nxt;
  mask_set_t               mask_r, mask_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]     out_status_r, out_status_nxt;
  logic [SLOT_F_W-1:0]     out_a_r, out_a_nxt;
  logic [SLOT_F_W-1:0]     out_b_r, out_b_nxt;
  logic                    out_hit_r, out_hit_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    held_v_r, held_v_nxt;
  logic [SLOT_W-1:0]       held_b_r, held_b_nxt;
  logic [SLOT_W-1:0]       k_r, k_nxt;
  logic [SLOT_W-1:0]       ev_k_r, ev_k_nxt;
  logic                    iss_done_r, iss_done_nxt;
  logic [PAIR_CNT_W-1:0]   n_r, n_nxt;
  logic [SLOT_W-1:0]       slot_idx_r, slot_idx_nxt;
  logic [SLOT_F_W-1:0]     slot5_r, slot5_nxt;
  entry_t                  item_r, item_nxt;
  entry_t                  base_r, base_nxt;
  logic [STATUS_W-1:0]     resp_status_r, resp_status_nxt;
  logic [SLOT_F_W-1:0]     resp_a_r, resp_a_nxt;

  mem_req_t                mem_req;
  entry_t                  rd_q;
  logic                    pair_hit;
  logic                    out_free;
  logic                    in_occ;
  logic [SLOT_W-1:0]       in_idx;
  logic                    pair;
  logic                    stall;

  apct_slot_mem #(.DEPTH(SLOT_COUNT)) u_mem (
    .clk  (clk),
    .req  (mem_req),
    .rd_q (rd_q)
  );

  apct_pair_eval #(.TYPE_COUNT(TYPE_COUNT)) u_eval (
    .base (base_r),
    .cand (rd_q),
    .mask (mask_r),
    .hit  (pair_hit)
  );

  assign in.ready   = (state_r == S_IDLE);
  assign out.valid  = out_valid_r;
  assign out.status = out_status_r;
  assign out.slot_a = out_a_r;
  assign out.slot_b = out_b_r;
  assign out.hit    = out_hit_r;
  assign out.last   = out_last_r;

  assign out_free = !out_valid_r || out.ready;
  assign in_idx   = SLOT_W'(in.slot);
  assign in_occ   = ({4'b0, in.slot} < 9'(SLOT_COUNT)) && valid_r[in_idx];
  assign pair     = valid_r[ev_k_r] && pair_hit && (n_r < PAIR_CNT_W'(MAX_PAIRS));
  assign stall    = pair && held_v_r && !out_free;

  always_comb begin
    state_nxt       = state_r;
    valid_nxt       = valid_r;
    mask_nxt        = mask_r;
    out_valid_nxt   = out_valid_r && !out.ready;
    out_status_nxt  = out_status_r;
    out_a_nxt       = out_a_r;
    out_b_nxt       = out_b_r;
    out_hit_nxt     = out_hit_r;
    out_last_nxt    = out_last_r;
    held_v_nxt      = held_v_r;
    held_b_nxt      = held_b_r;
    k_nxt           = k_r;
    ev_k_nxt        = ev_k_r;
    iss_done_nxt    = iss_done_r;
    n_nxt           = n_r;
    slot_idx_nxt    = slot_idx_r;
    slot5_nxt       = slot5_r;
    item_nxt        = item_r;
    base_nxt        = base_r;
    resp_status_nxt = resp_status_r;
    resp_a_nxt      = resp_a_r;
    mem_req         = '0;

    if (cfg_we) begin
      case (cfg_index)
        REG_MASK_0_3:   mask_nxt[0] = cfg_wdata;
        REG_MASK_4_7:   mask_nxt[1] = cfg_wdata;
        REG_MASK_8_11:  mask_nxt[2] = cfg_wdata;
        REG_MASK_12_15: mask_nxt[3] = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in.valid) begin
          item_nxt.obj_type = in.obj_type;
          item_nxt.rect.x   = in.rect_x;
          item_nxt.rect.y   = in.rect_y;
          item_nxt.rect.w   = in.rect_w;
          item_nxt.rect.h   = in.rect_h;
          slot_idx_nxt      = in_idx;
          slot5_nxt         = in.slot;
          n_nxt             = '0;
          held_v_nxt        = 1'b0;
          resp_a_nxt        = in.slot;
          resp_status_nxt   = in_occ ? ST_OK : ST_EMPTY;
          case (in.cmd)
            CMD_ADD: begin
              k_nxt     = '0;
              state_nxt = S_FIND;
            end
            CMD_REMOVE: begin
              if (in_occ) begin
                valid_nxt[in_idx] = 1'b0;
              end
              state_nxt = S_RESP;
            end
            CMD_UPDATE: begin
              mem_req.we_rect     = in_occ;
              mem_req.waddr       = SLOT_MAX_W'(in_idx);
              mem_req.wdata.rect  = item_nxt.rect;
              state_nxt = S_RESP;
            end
            CMD_SCAN: begin
              if (in_occ) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = SLOT_MAX_W'(in_idx);
                state_nxt     = S_BASE;
              end else begin
                state_nxt = S_RESP;
              end
            end
            default: ;
          endcase
        end
      end
      S_FIND: begin
        if (!valid_r[k_r]) begin
          valid_nxt[k_r]  = 1'b1;
          mem_req.we_rect = 1'b1;
          mem_req.we_type = 1'b1;
          mem_req.waddr   = SLOT_MAX_W'(k_r);
          mem_req.wdata   = item_r;
          resp_status_nxt = ST_OK;
          resp_a_nxt      = SLOT_F_W'(k_r);
          state_nxt       = S_RESP;
        end else if (k_r == LAST_IDX) begin
          resp_status_nxt = ST_FULL;
          resp_a_nxt      = '0;
          state_nxt       = S_RESP;
        end else begin
          k_nxt = SLOT_W'(k_r + 1'b1);
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = resp_status_r;
          out_a_nxt      = resp_a_r;
          out_b_nxt      = '0;
          out_hit_nxt    = 1'b0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_BASE: begin
        base_nxt = rd_q;
        if (slot_idx_r == LAST_IDX) begin
          state_nxt = S_FLUSH;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = SLOT_MAX_W'(slot_idx_r + 1'b1);
          ev_k_nxt      = SLOT_W'(slot_idx_r + 1'b1);
          k_nxt         = SLOT_W'(slot_idx_r + 2'd2);
          iss_done_nxt  = (SLOT_W'(slot_idx_r + 1'b1) == LAST_IDX);
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stall) begin
          if (pair) begin
            n_nxt      = PAIR_CNT_W'(n_r + 1'b1);
            held_v_nxt = 1'b1;
            held_b_nxt = ev_k_r;
            if (held_v_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OK;
              out_a_nxt      = slot5_r;
              out_b_nxt      = SLOT_F_W'(held_b_r);
              out_hit_nxt    = 1'b1;
              out_last_nxt   = 1'b0;
            end
          end
          if (iss_done_r) begin
            state_nxt = S_FLUSH;
          end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = SLOT_MAX_W'(k_r);
            ev_k_nxt      = k_r;
            k_nxt         = SLOT_W'(k_r + 1'b1);
            iss_done_nxt  = (k_r == LAST_IDX);
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_a_nxt      = slot5_r;
          out_b_nxt      = held_v_r ? SLOT_F_W'(held_b_r) : '0;
          out_hit_nxt    = held_v_r;
          out_last_nxt   = 1'b1;
          held_v_nxt     = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
      held_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
      held_v_r    <= held_v_nxt;
    end
    out_status_r  <= out_status_nxt;
    out_a_r       <= out_a_nxt;
    out_b_r       <= out_b_nxt;
    out_hit_r     <= out_hit_nxt;
    out_last_r    <= out_last_nxt;
    held_b_r      <= held_b_nxt;
    k_r           <= k_nxt;
    ev_k_r        <= ev_k_nxt;
    iss_done_r    <= iss_done_nxt;
    n_r           <= n_nxt;
    slot_idx_r    <= slot_idx_nxt;
    slot5_r       <= slot5_nxt;
    item_r        <= item_nxt;
    base_r        <= base_nxt;
    resp_status_r <= resp_status_nxt;
    resp_a_r      <= resp_a_nxt;
  end

endmodule

### rtl/apct_checker.sv
`timescale 1ns / 1ps

module apct_checker
  import apct_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [SLOT_F_W-1:0] out_slot_a,
  input logic [SLOT_F_W-1:0] out_slot_b,
  input logic                out_hit,
  input logic                out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_slot_a) && $stable(out_slot_b) && $stable(out_hit) && $stable(out_last))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_status == ST_OK)
    else $error("pair reported with bad status");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_last && out_slot_b == '0)
    else $error("non-pair result not final");

  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_slot_a == '0 && !out_hit)
    else $error("table full result malformed");

endmodule

bind aabb_pair_collision_table apct_checker u_apct_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out.valid),
  .out_ready  (out.ready),
  .out_status (out.status),
  .out_slot_a (out.slot_a),
  .out_slot_b (out.slot_b),
  .out_hit    (out.hit),
  .out_last   (out.last)
);

### tb/sv/aabb_pair_collision_table_test.sv
`timescale 1ns / 1ps

module aabb_pair_collision_table_test;
  import apct_pkg::*;

  localparam int SLOTS = SLOT_COUNT_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_TOP = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [SLOT_F_W-1:0] slot;
    rect_t               box;
    logic [TYPE_W-1:0]   kind;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_F_W-1:0] slot_a;
    logic [SLOT_F_W-1:0] slot_b;
    logic                hit;
    logic                last;
  } outcome_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [MASK_W-1:0]    cfg_wdata;

  apct_in_if  in_ch ();
  apct_out_if out_ch ();

  aabb_pair_collision_table uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in        (in_ch),
    .out       (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  request_t          cmd_queue [$];
  outcome_t          table_responses [$];
  logic [SLOTS-1:0]  plan_used;

  logic [SLOTS-1:0]  taken;
  rect_t             slot_box [SLOTS];
  logic [TYPE_W-1:0] slot_kind [SLOTS];
  logic [MASK_W-1:0] mask_rows [REG_COUNT];

  int send_gap_pct;
  int recv_stall_pct;
  bit hold_start;
  bit recv_blocked;
  int failures;
  int requests_taken;
  int results_seen;
  int pairs_predicted;
  int full_adds;
  int peak_pairs;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic bit pair_enabled(input logic [TYPE_W-1:0] r, input logic [TYPE_W-1:0] c);
    return mask_rows[r[3:2]][{r[1:0], c}];
  endfunction

  function automatic bit boxes_overlap(input rect_t a, input rect_t b);
    int ax, ay, bx, by;
    ax = $signed(a.x);
    ay = $signed(a.y);
    bx = $signed(b.x);
    by = $signed(b.y);
    return ax < bx + int'(b.w) && ax + int'(a.w) > bx &&
           ay < by + int'(b.h) && ay + int'(a.h) > by;
  endfunction

  task automatic predict_table_response(input request_t rq);
    outcome_t         o;
    int               found;
    int               total;
    int               count;
    logic [SLOTS-1:0] partners;
    o = '0;
    o.last = 1'b1;
    case (rq.cmd)
      CMD_ADD: begin
        found = -1;
        for (int i = 0; i < SLOTS; i++)
          if (!taken[i] && found < 0) found = i;
        if (found < 0) begin
          o.status = ST_FULL;
          full_adds++;
        end else begin
          taken[found] = 1'b1;
          slot_box[found] = rq.box;
          slot_kind[found] = rq.kind;
          o.slot_a = found[SLOT_F_W-1:0];
        end
        table_responses.push_back(o);
      end
      CMD_REMOVE, CMD_UPDATE: begin
        o.slot_a = rq.slot;
        if (!taken[rq.slot]) o.status = ST_EMPTY;
        else if (rq.cmd == CMD_REMOVE) taken[rq.slot] = 1'b0;
        else slot_box[rq.slot] = rq.box;
        table_responses.push_back(o);
      end
      default: begin
        o.slot_a = rq.slot;
        if (!taken[rq.slot]) begin
          o.status = ST_EMPTY;
          table_responses.push_back(o);
        end else begin
          partners = '0;
          for (int k = 0; k < SLOTS; k++)
            if (k > int'(rq.slot) && taken[k] &&
                pair_enabled(slot_kind[rq.slot], slot_kind[k]) &&
                boxes_overlap(slot_box[rq.slot], slot_box[k]))
              partners[k] = 1'b1;
          total = $countones(partners);
          if (total > MAX_PAIRS) total = MAX_PAIRS;
          if (total > peak_pairs) peak_pairs = total;
          pairs_predicted += total;
          if (total == 0) table_responses.push_back(o);
          count = 0;
          for (int k = 0; k < SLOTS; k++)
            if (partners[k] && count < total) begin
              o.slot_b = k[SLOT_F_W-1:0];
              o.hit = 1'b1;
              o.last = (count == total - 1);
              table_responses.push_back(o);
              count++;
            end
        end
      end
    endcase
  endtask

  task automatic compare_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : driver
    request_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_table_response({in_ch.cmd, in_ch.slot,
                                {in_ch.rect_x, in_ch.rect_y, in_ch.rect_w, in_ch.rect_h},
                                in_ch.obj_type});
        requests_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (cmd_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          nxt = cmd_queue.pop_front();
          in_ch.cmd <= nxt.cmd;
          in_ch.slot <= nxt.slot;
          in_ch.rect_x <= nxt.box.x;
          in_ch.rect_y <= nxt.box.y;
          in_ch.rect_w <= nxt.box.w;
          in_ch.rect_h <= nxt.box.h;
          in_ch.obj_type <= nxt.kind;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    outcome_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (table_responses.size() == 0) begin
          $error("unexpected result: status %0d slot_a %0d slot_b %0d hit %0d last %0d",
                 out_ch.status, out_ch.slot_a, out_ch.slot_b, out_ch.hit, out_ch.last);
          failures++;
        end else begin
          want = table_responses.pop_front();
          compare_field("status", want.status, out_ch.status);
          compare_field("slot_a", want.slot_a, out_ch.slot_a);
          compare_field("slot_b", want.slot_b, out_ch.slot_b);
          compare_field("hit", want.hit, out_ch.hit);
          compare_field("last", want.last, out_ch.last);
        end
      end
      out_ch.ready <= !recv_blocked && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    recv_blocked = 1'b0;
    wait (hold_start);
    @(posedge clk);
    recv_blocked <= 1'b1;
    repeat (300) @(posedge clk);
    recv_blocked <= 1'b0;
  end

  function automatic request_t make_request(input logic [CMD_W-1:0] cmd, input int slot,
                                            input int x, input int y, input int w, input int h,
                                            input int kind);
    request_t r;
    r.cmd = cmd;
    r.slot = slot[SLOT_F_W-1:0];
    r.box.x = x[COORD_W-1:0];
    r.box.y = y[COORD_W-1:0];
    r.box.w = w[SIZE_W-1:0];
    r.box.h = h[SIZE_W-1:0];
    r.kind = kind[TYPE_W-1:0];
    return r;
  endfunction

  function automatic rect_t random_box(input int spread);
    rect_t b;
    int    xv, yv;
    if ($urandom_range(99) < 15) begin
      b.x = COORD_W'($urandom_range(16'hFFFF));
      b.y = COORD_W'($urandom_range(16'hFFFF));
      b.w = SIZE_W'($urandom_range(12'hFFF));
      b.h = SIZE_W'($urandom_range(12'hFFF));
    end else begin
      xv = int'($urandom_range(2 * spread)) - spread;
      yv = int'($urandom_range(2 * spread)) - spread;
      b.x = xv[COORD_W-1:0];
      b.y = yv[COORD_W-1:0];
      b.w = SIZE_W'($urandom_range(spread + 40));
      b.h = SIZE_W'($urandom_range(spread + 40));
    end
    return b;
  endfunction

  function automatic logic [SLOT_F_W-1:0] pick_slot();
    logic [SLOT_F_W-1:0] s;
    s = SLOT_F_W'($urandom_range(SLOTS - 1));
    if (plan_used != '0 && $urandom_range(99) < 85)
      while (!plan_used[s]) s = SLOT_F_W'($urandom_range(SLOTS - 1));
    return s;
  endfunction

  task automatic queue_request(input request_t r);
    int found;
    found = -1;
    if (r.cmd == CMD_ADD) begin
      for (int i = 0; i < SLOTS; i++)
        if (!plan_used[i] && found < 0) found = i;
      if (found >= 0) plan_used[found] = 1'b1;
    end else if (r.cmd == CMD_REMOVE) begin
      plan_used[r.slot] = 1'b0;
    end
    cmd_queue.push_back(r);
  endtask

  task automatic queue_mixed(input int count, input int spread);
    request_t r;
    int       roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      r.cmd = roll < 30 ? CMD_ADD : roll < 45 ? CMD_REMOVE : roll < 65 ? CMD_UPDATE : CMD_SCAN;
      r.slot = pick_slot();
      r.box = random_box(spread);
      r.kind = TYPE_W'($urandom_range(15));
      queue_request(r);
    end
  endtask

  task automatic queue_fill();
    request_t r;
    while (plan_used != '1) begin
      r = make_request(CMD_ADD, $urandom_range(31), 0, 0, 0, 0, $urandom_range(15));
      r.box = random_box(30);
      queue_request(r);
    end
    for (int n = 0; n < 2; n++)
      queue_request(make_request(CMD_ADD, n, -5, -5, 50, 50, n));
    for (int s = 0; s < 4; s++)
      queue_request(make_request(CMD_SCAN, s, 0, 0, 0, 0, 0));
    queue_mixed(6, 30);
  endtask

  task automatic program_masks(input logic [MASK_W-1:0] r0, input logic [MASK_W-1:0] r1,
                               input logic [MASK_W-1:0] r2, input logic [MASK_W-1:0] r3);
    logic [MASK_W-1:0]    rows [REG_COUNT];
    logic [CFG_IDX_W-1:0] regs [REG_COUNT];
    rows = '{r0, r1, r2, r3};
    regs = '{REG_MASK_0_3, REG_MASK_4_7, REG_MASK_8_11, REG_MASK_12_15};
    cfg_we <= 1'b1;
    cfg_index <= REG_SPARE;
    cfg_wdata <= ~r0;
    @(posedge clk);
    for (int i = 0; i < REG_COUNT; i++) begin
      cfg_index <= regs[i];
      cfg_wdata <= rows[i];
      mask_rows[i] = rows[i];
      @(posedge clk);
    end
    cfg_index <= REG_SPARE_TOP;
    cfg_wdata <= {r3[31:0], r2[31:0]};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (cmd_queue.size() != 0 || in_ch.valid || table_responses.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [MASK_W-1:0] random_mask();
    return {$urandom, $urandom};
  endfunction

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_ADD;
    in_ch.slot = '0;
    in_ch.rect_x = '0;
    in_ch.rect_y = '0;
    in_ch.rect_w = '0;
    in_ch.rect_h = '0;
    in_ch.obj_type = '0;
    out_ch.ready = 1'b0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    hold_start = 1'b0;
    plan_used = '0;
    taken = '0;
    for (int i = 0; i < REG_COUNT; i++) mask_rows[i] = '0;
    failures = 0;
    requests_taken = 0;
    results_seen = 0;
    pairs_predicted = 0;
    full_adds = 0;
    peak_pairs = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    program_masks('1, '1, '1, '1);
    queue_request(make_request(CMD_SCAN, 0, 0, 0, 0, 0, 0));
    queue_request(make_request(CMD_REMOVE, 31, 0, 0, 0, 0, 0));
    queue_request(make_request(CMD_UPDATE, 5, 1, 1, 1, 1, 1));
    queue_request(make_request(CMD_ADD, 0, -32768, -32768, 4095, 4095, 0));
    queue_request(make_request(CMD_ADD, 0, 32767, 32767, 4095, 4095, 15));
    queue_request(make_request(CMD_ADD, 0, -32668, -32668, 0, 10, 15));
    queue_request(make_request(CMD_ADD, 0, -32718, -32718, 1, 1, 7));
    queue_request(make_request(CMD_ADD, 0, -28673, -32768, 10, 10, 0));
    queue_request(make_request(CMD_SCAN, 0, 0, 0, 0, 0, 0));
    queue_request(make_request(CMD_SCAN, 1, 0, 0, 0, 0, 0));
    queue_request(make_request(CMD_SCAN, 4, 0, 0, 0, 0, 0));
    queue_request(make_request(CMD_UPDATE, 4, -28674, -32768, 10, 10, 9));
    queue_request(make_request(CMD_SCAN, 0, 0, 0, 0, 0, 0));
    queue_request(make_request(CMD_REMOVE, 2, 0, 0, 0, 0, 0));
    queue_request(make_request(CMD_SCAN, 0, 0, 0, 0, 0, 0));
    queue_request(make_request(CMD_ADD, 0, 0, 0, 100, 100, 5));
    queue_request(make_request(CMD_SCAN, 31, 0, 0, 0, 0, 0));
    queue_request(make_request(CMD_REMOVE, 2, 0, 0, 0, 0, 0));
    queue_request(make_request(CMD_REMOVE, 2, 0, 0, 0, 0, 0));
    queue_request(make_request(CMD_SCAN, 3, 0, 0, 0, 0, 0));
    wait_idle();

    send_gap_pct = 58;
    program_masks(random_mask(), random_mask(), random_mask(), random_mask());
    queue_mixed(35, 100);
    wait_idle();

    send_gap_pct = 0;
    recv_stall_pct = 58;
    program_masks('0, '0, '0, '0);
    queue_mixed(25, 100);
    wait_idle();

    send_gap_pct = 20;
    recv_stall_pct = 20;
    program_masks('1, '1, '1, '1);
    hold_start = 1'b1;
    queue_fill();
    wait_idle();

    send_gap_pct = 0;
    recv_stall_pct = 0;
    program_masks(random_mask() & random_mask(), random_mask() & random_mask(),
                  random_mask(), random_mask() | random_mask());
    queue_mixed(45, 60);
    wait_idle();
    repeat (SLOTS + 8) @(posedge clk);

    if (table_responses.size() != 0) begin
      $error("%0d expected results never arrived", table_responses.size());
      failures++;
    end
    $display("Ran %0d requests giving %0d results over five pair-mask settings and idle patterns,",
             requests_taken, results_seen);
    $display("with %0d collision pairs, %0d adds on a full table and up to %0d pairs in one scan.",
             pairs_predicted, full_adds, peak_pairs);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
